// ===== rtl/bbatk_pkg.sv =====
// Package for the bitboard attack generator: payload types, command codes and board geometry.
`default_nettype none

package bbatk_pkg;

  // Command codes carried in the query's command field.
  typedef enum logic [3:0] {
    CMD_KNIGHT   = 4'd0,
    CMD_KING     = 4'd1,
    CMD_PAWN_CAP = 4'd2,
    CMD_PAWN_ATK = 4'd3,
    CMD_BISHOP   = 4'd4,
    CMD_ROOK     = 4'd5,
    CMD_QUEEN    = 4'd6,
    CMD_RAY      = 4'd7,
    CMD_BLOCKER  = 4'd8
  } cmd_t;

  // One query item.
  typedef struct packed {
    logic [3:0]  command;
    logic [5:0]  square;
    logic        black_side;
    logic [2:0]  direction;
    logic [63:0] occupied;
  } query_t;

  // One result item.
  typedef struct packed {
    logic [63:0] attacks;
    logic        blocker_found;
    logic [5:0]  blocker_square;
  } result_t;

  // Outcome of walking one ray.
  typedef struct packed {
    logic [63:0] mask;
    logic        found;
    logic [5:0]  hit;
  } ray_t;

  // Board coordinates are held signed so that steps off the board stay visible.
  typedef logic signed [4:0] coord_t;

  // Ray steps for N, NE, E, SE, S, SW, W, NW.
  localparam coord_t FILE_STEP [8] = '{5'sd0, 5'sd1, 5'sd1, 5'sd1, 5'sd0, -5'sd1, -5'sd1, -5'sd1};
  localparam coord_t RANK_STEP [8] = '{5'sd1, 5'sd1, 5'sd0, -5'sd1, -5'sd1, -5'sd1, 5'sd0, 5'sd1};

  // Knight jumps.
  localparam coord_t JUMP_FILE [8] = '{5'sd1, 5'sd2, 5'sd2, 5'sd1, -5'sd1, -5'sd2, -5'sd2, -5'sd1};
  localparam coord_t JUMP_RANK [8] = '{5'sd2, 5'sd1, -5'sd1, -5'sd2, -5'sd2, -5'sd1, 5'sd1, 5'sd2};

  // A coordinate is on the board when it lies in 0..7.
  function automatic logic on_board(input coord_t f, input coord_t r);
    return (f[4:3] == 2'b00) && (r[4:3] == 2'b00);
  endfunction

  // One-hot mask of a square, or zero when the square is off the board.
  function automatic logic [63:0] bit_at(input coord_t f, input coord_t r);
    logic [63:0] m;
    m = '0;
    if (on_board(f, r)) begin
      m[{r[2:0], f[2:0]}] = 1'b1;
    end
    return m;
  endfunction

  // Walk one ray outward from a square. The first occupied square is recorded,
  // and when stop is set the ray ends there (that square included).
  function automatic ray_t walk_ray(input logic [5:0] sq, input logic [2:0] dir,
                                    input logic [63:0] occ, input logic stop);
    ray_t   res;
    coord_t f;
    coord_t r;
    logic   live;
    logic [5:0] idx;
    res  = '0;
    f    = coord_t'({2'b00, sq[2:0]});
    r    = coord_t'({2'b00, sq[5:3]});
    live = 1'b1;
    idx  = '0;
    for (int i = 0; i < 7; i++) begin
      f = f + FILE_STEP[dir];
      r = r + RANK_STEP[dir];
      if (live && on_board(f, r)) begin
        idx = {r[2:0], f[2:0]};
        res.mask[idx] = 1'b1;
        if (occ[idx] && !res.found) begin
          res.found = 1'b1;
          res.hit   = idx;
          if (stop) begin
            live = 1'b0;
          end
        end
      end else begin
        live = 1'b0;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bitboard_attack_generator.sv =====
// Top level of the bitboard attack generator: query register, attack logic, result register.
//
//   Channel | Handshake                   | Payload
//   --------+-----------------------------+------------------------------
//   query   | query_valid / query_ready   | query  (bbatk_pkg::query_t)
//   result  | result_valid / result_ready | result (bbatk_pkg::result_t)
//
// One query is taken per cycle while query_ready is high; its result passes through the query
// register and then the result register, from which it is offered.
// Reset clears both valid flags; the query and result data registers are not reset.
// A stalled result holds in the result register while one more query waits in the
// query register, so query_ready drops only when both are full.
`default_nettype none

module bitboard_attack_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               query_valid,
  output logic               query_ready,
  input  bbatk_pkg::query_t  query,
  output logic               result_valid,
  input  logic               result_ready,
  output bbatk_pkg::result_t result
);

  import bbatk_pkg::*;

  query_t  q;
  logic    q_valid;
  logic    advance;
  result_t result_next;
  ray_t    rays [8];
  ray_t    raw_ray;
  coord_t  f;
  coord_t  r;
  coord_t  pawn_fwd;

  // Handshake: the query register moves on whenever the result register frees up.
  assign advance     = !result_valid || result_ready;
  assign query_ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (query_ready) begin
        q_valid <= query_valid;
      end
      if (advance) begin
        result_valid <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_valid && query_ready) begin
      q <= query;
    end
    if (advance && q_valid) begin
      result <= result_next;
    end
  end

  // Blocked rays in all eight directions, plus the unblocked ray for the raw command.
  always_comb begin
    for (int d = 0; d < 8; d++) begin
      rays[d] = walk_ray(q.square, 3'(d), q.occupied, 1'b1);
    end
    raw_ray = walk_ray(q.square, q.direction, 64'd0, 1'b0);
  end

  assign f        = coord_t'({2'b00, q.square[2:0]});
  assign r        = coord_t'({2'b00, q.square[5:3]});
  assign pawn_fwd = q.black_side ? -5'sd1 : 5'sd1;

  // Attack pattern selection by command.
  always_comb begin
    result_next = '0;
    case (q.command)
      CMD_KNIGHT: begin
        for (int i = 0; i < 8; i++) begin
          result_next.attacks |= bit_at(f + JUMP_FILE[i], r + JUMP_RANK[i]);
        end
      end
      CMD_KING: begin
        for (int i = 0; i < 8; i++) begin
          result_next.attacks |= bit_at(f + FILE_STEP[i], r + RANK_STEP[i]);
        end
      end
      CMD_PAWN_CAP: begin
        result_next.attacks = bit_at(f - 5'sd1, r + pawn_fwd) | bit_at(f + 5'sd1, r + pawn_fwd);
      end
      CMD_PAWN_ATK: begin
        result_next.attacks = bit_at(f - 5'sd1, r - pawn_fwd) | bit_at(f + 5'sd1, r - pawn_fwd);
      end
      CMD_BISHOP: begin
        for (int d = 1; d < 8; d += 2) begin
          result_next.attacks |= rays[d].mask;
        end
      end
      CMD_ROOK: begin
        for (int d = 0; d < 8; d += 2) begin
          result_next.attacks |= rays[d].mask;
        end
      end
      CMD_QUEEN: begin
        for (int d = 0; d < 8; d++) begin
          result_next.attacks |= rays[d].mask;
        end
      end
      CMD_RAY: begin
        result_next.attacks = raw_ray.mask;
      end
      CMD_BLOCKER: begin
        result_next.blocker_found  = rays[q.direction].found;
        result_next.blocker_square = rays[q.direction].hit;
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  // A held query always reaches the result register once that register is free.
  assert property (@(posedge clk) disable iff (rst) q_valid && advance |=> result_valid)
    else $error("query in flight was not moved into the result register");

  // No blocker means the reported square is zero.
  assert property (@(posedge clk) disable iff (rst)
                   result_valid && !result.blocker_found |-> result.blocker_square == 6'd0)
    else $error("blocker square set without a blocker");

  // Blocker results carry no attack mask.
  assert property (@(posedge clk) disable iff (rst)
                   result_valid && result.blocker_found |-> result.attacks == 64'd0)
    else $error("attack mask set on a blocker result");

  // No piece on an 8x8 board attacks more than 27 squares.
  assert property (@(posedge clk) disable iff (rst)
                   result_valid |-> $countones(result.attacks) <= 27)
    else $error("attack mask too large");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the bitboard attack generator with its own attack predictor.

module tb;
  import bbatk_pkg::*;

  // Ray directions in the order of the direction field.
  typedef enum int {
    DIR_N, DIR_NE, DIR_E, DIR_SE, DIR_S, DIR_SW, DIR_W, DIR_NW
  } ray_dir_e;

  // Command codes that the block does not define; they must give an all-zero result.
  localparam logic [3:0] CMD_SPARE_FIRST = 4'd9;
  localparam logic [3:0] CMD_SPARE_LAST  = 4'd15;

  localparam logic [63:0] BOARD_EMPTY = 64'd0;
  localparam logic [63:0] BOARD_FULL  = {64{1'b1}};

  logic    clk;
  logic    rst;
  logic    query_valid;
  logic    query_ready;
  query_t  query;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  // Predicted results of accepted queries, oldest first.
  result_t pending_attacks[$];
  int      mismatch_count;
  int      result_count;
  int      send_idle_pct;
  int      recv_idle_pct;

  bitboard_attack_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_ready  (query_ready),
    .query        (query),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  // One-hot mask of a square, zero when the coordinates leave the board.
  function automatic logic [63:0] square_mask(input int f, input int r);
    if (f < 0 || f > 7 || r < 0 || r > 7) begin
      return BOARD_EMPTY;
    end
    return 64'd1 << (r * 8 + f);
  endfunction

  // File and rank step of one ray direction.
  function automatic void ray_step(input int d, output int df, output int dr);
    case (d)
      DIR_N:   begin df =  0; dr =  1; end
      DIR_NE:  begin df =  1; dr =  1; end
      DIR_E:   begin df =  1; dr =  0; end
      DIR_SE:  begin df =  1; dr = -1; end
      DIR_S:   begin df =  0; dr = -1; end
      DIR_SW:  begin df = -1; dr = -1; end
      DIR_W:   begin df = -1; dr =  0; end
      default: begin df = -1; dr =  1; end
    endcase
  endfunction

  // Squares on a ray up to and including the first occupied one; hit is that square or -1.
  function automatic logic [63:0] trace_ray(input int sq, input int d, input logic [63:0] occ,
                                            output int hit);
    int f;
    int r;
    int df;
    int dr;
    logic [63:0] m;
    ray_step(d, df, dr);
    f   = sq % 8 + df;
    r   = sq / 8 + dr;
    m   = BOARD_EMPTY;
    hit = -1;
    while (f >= 0 && f < 8 && r >= 0 && r < 8) begin
      m = m | square_mask(f, r);
      if (occ[r * 8 + f]) begin
        hit = r * 8 + f;
        break;
      end
      f = f + df;
      r = r + dr;
    end
    return m;
  endfunction

  // Expected result of one query.
  function automatic result_t predict_attacks(input query_t q);
    result_t res;
    int f;
    int r;
    int fwd;
    int df;
    int dr;
    int d;
    int hit;
    logic [63:0] unused_mask;
    res = '0;
    f   = q.square[2:0];
    r   = q.square[5:3];
    fwd = q.black_side ? -1 : 1;
    case (q.command)
      CMD_KNIGHT: begin
        for (df = -2; df <= 2; df++) begin
          for (dr = -2; dr <= 2; dr++) begin
            if (df * df + dr * dr == 5) begin
              res.attacks = res.attacks | square_mask(f + df, r + dr);
            end
          end
        end
      end
      CMD_KING: begin
        for (df = -1; df <= 1; df++) begin
          for (dr = -1; dr <= 1; dr++) begin
            if (df != 0 || dr != 0) begin
              res.attacks = res.attacks | square_mask(f + df, r + dr);
            end
          end
        end
      end
      CMD_PAWN_CAP: begin
        res.attacks = square_mask(f - 1, r + fwd) | square_mask(f + 1, r + fwd);
      end
      CMD_PAWN_ATK: begin
        res.attacks = square_mask(f - 1, r - fwd) | square_mask(f + 1, r - fwd);
      end
      CMD_BISHOP: begin
        for (d = DIR_NE; d <= DIR_NW; d += 2) begin
          res.attacks = res.attacks | trace_ray(q.square, d, q.occupied, hit);
        end
      end
      CMD_ROOK: begin
        for (d = DIR_N; d <= DIR_W; d += 2) begin
          res.attacks = res.attacks | trace_ray(q.square, d, q.occupied, hit);
        end
      end
      CMD_QUEEN: begin
        for (d = DIR_N; d <= DIR_NW; d++) begin
          res.attacks = res.attacks | trace_ray(q.square, d, q.occupied, hit);
        end
      end
      CMD_RAY: begin
        res.attacks = trace_ray(q.square, q.direction, BOARD_EMPTY, hit);
      end
      CMD_BLOCKER: begin
        unused_mask = trace_ray(q.square, q.direction, q.occupied, hit);
        if (hit >= 0) begin
          res.blocker_found  = 1'b1;
          res.blocker_square = hit[5:0];
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", result_count, what, got, want);
    mismatch_count++;
  endtask

  // Result checker. Each result transfer is compared with the oldest prediction, and each
  // query transfer adds its prediction.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (pending_attacks.size() == 0) begin
          report_mismatch("unexpected result", result.attacks, BOARD_EMPTY);
        end else begin
          want = pending_attacks.pop_front();
          if (result.attacks !== want.attacks) begin
            report_mismatch("attacks", result.attacks, want.attacks);
          end
          if (result.blocker_found !== want.blocker_found) begin
            report_mismatch("blocker_found", 64'(result.blocker_found),
                            64'(want.blocker_found));
          end
          if (result.blocker_square !== want.blocker_square) begin
            report_mismatch("blocker_square", 64'(result.blocker_square),
                            64'(want.blocker_square));
          end
        end
        result_count++;
      end
      if (query_valid && query_ready) begin
        pending_attacks.push_back(predict_attacks(query));
      end
    end
  end

  // Receiver stalls at random.
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one query. Called and returns at a falling edge; valid stays high afterwards
  // so that back-to-back transfers are possible.
  task automatic send_query(input query_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      query_valid <= 1'b0;
      @(negedge clk);
    end
    query_valid <= 1'b1;
    query       <= q;
    @(posedge clk);
    while (!query_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Holds off the sender until every predicted result has arrived.
  task automatic drain_results();
    query_valid <= 1'b0;
    while (pending_attacks.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  function automatic query_t make_query(input logic [3:0] cmd, input int sq, input bit black,
                                        input int d, input logic [63:0] occ);
    query_t q;
    q.command    = cmd;
    q.square     = sq[5:0];
    q.black_side = black;
    q.direction  = d[2:0];
    q.occupied   = occ;
    return q;
  endfunction

  // Random query; occupancy ranges from empty through sparse to full.
  function automatic query_t random_query();
    query_t q;
    q.square     = 6'($urandom_range(63));
    q.black_side = 1'($urandom_range(1));
    q.direction  = 3'($urandom_range(7));
    if ($urandom_range(99) < 4) begin
      q.command = 4'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    end else begin
      q.command = 4'($urandom_range(CMD_BLOCKER));
    end
    case ($urandom_range(7))
      0:       q.occupied = BOARD_EMPTY;
      1:       q.occupied = BOARD_FULL;
      2, 3:    q.occupied = {$urandom, $urandom};
      4, 5:    q.occupied = {$urandom, $urandom} & {$urandom, $urandom};
      default: q.occupied = {$urandom, $urandom} & {$urandom, $urandom} &
                            {$urandom, $urandom};
    endcase
    return q;
  endfunction

  // Knight and king patterns in corners and the center.
  task automatic test_leaper_patterns();
    send_query(make_query(CMD_KNIGHT, 0, 1'b0, DIR_N, BOARD_EMPTY));
    send_query(make_query(CMD_KNIGHT, 63, 1'b1, DIR_NW, BOARD_FULL));
    send_query(make_query(CMD_KNIGHT, 36, 1'b0, DIR_E, BOARD_EMPTY));
    send_query(make_query(CMD_KING, 0, 1'b1, DIR_S, BOARD_FULL));
    send_query(make_query(CMD_KING, 63, 1'b0, DIR_N, BOARD_EMPTY));
    send_query(make_query(CMD_KING, 27, 1'b0, DIR_N, BOARD_EMPTY));
  endtask

  // Pawn captures and attackers for both sides, on the edge files, on last ranks and in the center.
  task automatic test_pawn_patterns();
    send_query(make_query(CMD_PAWN_CAP, 8, 1'b0, DIR_N, BOARD_EMPTY));
    send_query(make_query(CMD_PAWN_CAP, 63, 1'b0, DIR_N, BOARD_EMPTY));
    send_query(make_query(CMD_PAWN_CAP, 7, 1'b1, DIR_N, BOARD_EMPTY));
    send_query(make_query(CMD_PAWN_CAP, 55, 1'b1, DIR_N, BOARD_FULL));
    send_query(make_query(CMD_PAWN_ATK, 0, 1'b0, DIR_N, BOARD_EMPTY));
    send_query(make_query(CMD_PAWN_ATK, 36, 1'b1, DIR_N, BOARD_EMPTY));
  endtask

  // Sliders on an empty board, a full board and a random one.
  task automatic test_sliders();
    send_query(make_query(CMD_BISHOP, 27, 1'b0, DIR_N, BOARD_EMPTY));
    send_query(make_query(CMD_ROOK, 0, 1'b1, DIR_SE, BOARD_FULL));
    send_query(make_query(CMD_QUEEN, 36, 1'b0, DIR_N, {$urandom, $urandom}));
  endtask

  // Raw rays ignore occupancy; blocker search at the edge, far away, absent and adjacent.
  task automatic test_rays_and_blockers();
    send_query(make_query(CMD_RAY, 0, 1'b0, DIR_N, BOARD_FULL));
    send_query(make_query(CMD_RAY, 0, 1'b1, DIR_S, BOARD_EMPTY));
    send_query(make_query(CMD_BLOCKER, 7, 1'b0, DIR_E, BOARD_FULL));
    send_query(make_query(CMD_BLOCKER, 7, 1'b0, DIR_W, 64'd1));
    send_query(make_query(CMD_BLOCKER, 0, 1'b0, DIR_NE, BOARD_EMPTY));
    send_query(make_query(CMD_BLOCKER, 63, 1'b1, DIR_SW, BOARD_FULL));
  endtask

  // Undefined commands with every other field set.
  task automatic test_spare_commands();
    send_query(make_query(CMD_SPARE_FIRST, 63, 1'b1, DIR_NW, BOARD_FULL));
    send_query(make_query(CMD_SPARE_LAST, 63, 1'b1, DIR_NW, BOARD_FULL));
  endtask

  // A stretch of random queries under one pattern of stalls, drained at the end.
  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    int n;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (n = 0; n < count; n++) begin
      send_query(random_query());
    end
    drain_results();
  endtask

  initial begin
    rst            = 1'b1;
    query_valid    = 1'b0;
    query          = '0;
    result_ready   = 1'b0;
    mismatch_count = 0;
    result_count   = 0;
    send_idle_pct  = 13;
    recv_idle_pct  = 84;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_leaper_patterns();
    test_pawn_patterns();
    test_sliders();
    test_rays_and_blockers();
    test_spare_commands();
    drain_results();

    test_random_traffic(630, 13, 84);
    test_random_traffic(630, 84, 13);
    test_random_traffic(640, 0, 0);

    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending_attacks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
